[src/cpu_load_store_unit_core_defines.svh]
// assertion macros shared by the load/store unit modules
`ifndef CPU_LOAD_STORE_UNIT_CORE_DEFINES_SVH
`define CPU_LOAD_STORE_UNIT_CORE_DEFINES_SVH

// condition that must hold at every clock edge
`define CLSU_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define CLSU_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

[src/clsu_pkg.sv]
// types, codes and constants of the load/store unit
package clsu_pkg;

	localparam logic [1:0] RK_READ  = 2'd0;
	localparam logic [1:0] RK_WRITE = 2'd1;
	localparam logic [1:0] RK_DONE  = 2'd2;

	localparam logic [2:0] REG_A = 3'd0;
	localparam logic [2:0] REG_B = 3'd1;
	localparam logic [2:0] REG_C = 3'd2;
	localparam logic [2:0] REG_D = 3'd3;
	localparam logic [2:0] REG_E = 3'd4;
	localparam logic [2:0] REG_H = 3'd5;
	localparam logic [2:0] REG_L = 3'd6;

	localparam logic [3:0] DEST_SP   = 4'd7;
	localparam logic [3:0] DEST_NONE = 4'd8;

	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_INC  = 2'd1;
	localparam logic [1:0] STEP_DEC  = 2'd2;

	localparam logic [2:0] CODE_HL_IND = 3'd6;

	localparam logic [15:0] HIGH_PAGE = 16'hFF00;

	localparam logic [7:0] OP_HALT        = 8'h76;
	localparam logic [7:0] OP_LD_HL_IND_N = 8'h36;
	localparam logic [7:0] OP_LD_BC_NN    = 8'h01;
	localparam logic [7:0] OP_LD_DE_NN    = 8'h11;
	localparam logic [7:0] OP_LD_HL_NN    = 8'h21;
	localparam logic [7:0] OP_LD_SP_NN    = 8'h31;
	localparam logic [7:0] OP_LD_SP_HL    = 8'hF9;
	localparam logic [7:0] OP_LD_A_BC     = 8'h0A;
	localparam logic [7:0] OP_LD_A_DE     = 8'h1A;
	localparam logic [7:0] OP_LD_A_NN     = 8'hFA;
	localparam logic [7:0] OP_LD_A_HLI    = 8'h2A;
	localparam logic [7:0] OP_LD_A_HLD    = 8'h3A;
	localparam logic [7:0] OP_LDH_A_N     = 8'hF0;
	localparam logic [7:0] OP_LD_BC_A     = 8'h02;
	localparam logic [7:0] OP_LD_DE_A     = 8'h12;
	localparam logic [7:0] OP_LD_NN_A     = 8'hEA;
	localparam logic [7:0] OP_LDH_C_A     = 8'hE2;
	localparam logic [7:0] OP_LDH_N_A     = 8'hE0;
	localparam logic [7:0] OP_LD_HLI_A    = 8'h22;
	localparam logic [7:0] OP_LD_HLD_A    = 8'h32;
	localparam logic [7:0] OP_LD_NN_SP    = 8'h08;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [4:0]  cycles;
		logic        unsupported;
		logic [3:0]  dest_index;
		logic [15:0] dest_value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [6:0][7:0] regs;
		logic [15:0]     sp;
		logic            read_pending;
		logic [2:0]      pend_target;
		logic [1:0]      pend_step;
		logic [4:0]      pend_cycles;
	} state_t;

	function automatic result_t mk_result(input logic [1:0] kind, input logic [15:0] addr,
			input logic [7:0] data, input logic [4:0] cyc, input logic unsup,
			input logic [3:0] dest, input logic [15:0] val);
		result_t r;
		r.kind        = kind;
		r.address     = addr;
		r.write_data  = data;
		r.cycles      = cyc;
		r.unsupported = unsup;
		r.dest_index  = dest;
		r.dest_value  = val;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

[src/clsu_exec.sv]
// decode and execute of one item against the register state
module clsu_exec import clsu_pkg::*; (
	input  logic                 kind,
	input  logic [7:0]           opcode,
	input  logic [7:0]           imm_low,
	input  logic [7:0]           imm_high,
	input  logic [7:0]           read_data,
	input  state_t               st,
	output result_t [2:0]        res,
	output logic [1:0]           cnt,
	output state_t               nxt
);

	function automatic logic [2:0] code_to_reg(input logic [2:0] code);
		logic [2:0] r;
		case (code)
			3'd0: r = REG_B;
			3'd1: r = REG_C;
			3'd2: r = REG_D;
			3'd3: r = REG_E;
			3'd4: r = REG_H;
			3'd5: r = REG_L;
			3'd7: r = REG_A;
			default: r = REG_A;
		endcase
		return r;
	endfunction

	always_comb begin
		logic [6:0][7:0] regs_v;
		logic [15:0]     hl;
		logic [15:0]     nn;
		logic [15:0]     nv;
		logic [7:0]      a;
		logic [2:0]      dst;
		logic [2:0]      src;
		logic [2:0]      t;
		result_t         none_r;

		none_r = mk_result(RK_DONE, 16'h0, 8'h0, 5'd0, 1'b0, DEST_NONE, 16'h0);
		res    = {none_r, none_r, none_r};
		cnt    = 2'd0;
		nxt    = st;
		regs_v = st.regs;
		hl     = {st.regs[REG_H], st.regs[REG_L]};
		nn     = {imm_high, imm_low};
		a      = st.regs[REG_A];
		dst    = code_to_reg(opcode[5:3]);
		src    = code_to_reg(opcode[2:0]);
		nv     = 16'h0;
		t      = st.pend_target;

		if (!kind) begin
			nxt.read_pending = 1'b0;
			cnt = 2'd1;
			if (opcode[7:6] == 2'b01 && opcode != OP_HALT) begin
				if (opcode[5:3] == CODE_HL_IND) begin
					res[0] = mk_result(RK_WRITE, hl, st.regs[src], 5'd0, 1'b0, DEST_NONE, 16'h0);
					res[1] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd8, 1'b0, DEST_NONE, 16'h0);
					cnt = 2'd2;
				end else if (opcode[2:0] == CODE_HL_IND) begin
					res[0] = mk_result(RK_READ, hl, 8'h0, 5'd0, 1'b0, DEST_NONE, 16'h0);
					nxt.read_pending = 1'b1;
					nxt.pend_target  = dst;
					nxt.pend_step    = STEP_NONE;
					nxt.pend_cycles  = 5'd8;
				end else begin
					nxt.regs[dst] = st.regs[src];
					res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd4, 1'b0, {1'b0, dst},
						{8'h0, st.regs[src]});
				end
			end else if ((opcode & 8'hC7) == 8'h06 && opcode != OP_LD_HL_IND_N) begin
				nxt.regs[dst] = imm_low;
				res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd8, 1'b0, {1'b0, dst}, {8'h0, imm_low});
			end else begin
				case (opcode)
					OP_LD_BC_NN: begin
						nxt.regs[REG_B] = imm_high;
						nxt.regs[REG_C] = imm_low;
						res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd12, 1'b0, {1'b0, REG_B}, nn);
					end
					OP_LD_DE_NN: begin
						nxt.regs[REG_D] = imm_high;
						nxt.regs[REG_E] = imm_low;
						res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd12, 1'b0, {1'b0, REG_D}, nn);
					end
					OP_LD_HL_NN: begin
						nxt.regs[REG_H] = imm_high;
						nxt.regs[REG_L] = imm_low;
						res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd12, 1'b0, {1'b0, REG_H}, nn);
					end
					OP_LD_SP_NN: begin
						nxt.sp = nn;
						res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd12, 1'b0, DEST_SP, nn);
					end
					OP_LD_SP_HL: begin
						nxt.sp = hl;
						res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd8, 1'b0, DEST_SP, hl);
					end
					OP_LD_HL_IND_N: begin
						res[0] = mk_result(RK_WRITE, hl, imm_low, 5'd0, 1'b0, DEST_NONE, 16'h0);
						res[1] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd12, 1'b0, DEST_NONE, 16'h0);
						cnt = 2'd2;
					end
					OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_NN, OP_LD_A_HLI, OP_LD_A_HLD,
					OP_LDH_A_N: begin
						nxt.read_pending = 1'b1;
						nxt.pend_target  = REG_A;
						nxt.pend_step    = STEP_NONE;
						nxt.pend_cycles  = 5'd8;
						nv = hl;
						case (opcode)
							OP_LD_A_BC: nv = {st.regs[REG_B], st.regs[REG_C]};
							OP_LD_A_DE: nv = {st.regs[REG_D], st.regs[REG_E]};
							OP_LD_A_NN: begin
								nv = nn;
								nxt.pend_cycles = 5'd16;
							end
							OP_LD_A_HLI: nxt.pend_step = STEP_INC;
							OP_LD_A_HLD: nxt.pend_step = STEP_DEC;
							OP_LDH_A_N: begin
								nv = HIGH_PAGE | {8'h0, imm_low};
								nxt.pend_cycles = 5'd12;
							end
							default: nv = hl;
						endcase
						res[0] = mk_result(RK_READ, nv, 8'h0, 5'd0, 1'b0, DEST_NONE, 16'h0);
					end
					OP_LD_BC_A, OP_LD_DE_A, OP_LD_NN_A, OP_LDH_C_A, OP_LDH_N_A: begin
						res[1] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd8, 1'b0, DEST_NONE, 16'h0);
						case (opcode)
							OP_LD_BC_A: nv = {st.regs[REG_B], st.regs[REG_C]};
							OP_LD_DE_A: nv = {st.regs[REG_D], st.regs[REG_E]};
							OP_LD_NN_A: begin
								nv = nn;
								res[1].cycles = 5'd16;
							end
							OP_LDH_C_A: nv = HIGH_PAGE | {8'h0, st.regs[REG_C]};
							OP_LDH_N_A: begin
								nv = HIGH_PAGE | {8'h0, imm_low};
								res[1].cycles = 5'd12;
							end
							default: nv = nn;
						endcase
						res[0] = mk_result(RK_WRITE, nv, a, 5'd0, 1'b0, DEST_NONE, 16'h0);
						cnt = 2'd2;
					end
					OP_LD_HLI_A, OP_LD_HLD_A: begin
						nv = (opcode == OP_LD_HLI_A) ? hl + 16'd1 : hl - 16'd1;
						nxt.regs[REG_H] = nv[15:8];
						nxt.regs[REG_L] = nv[7:0];
						res[0] = mk_result(RK_WRITE, hl, a, 5'd0, 1'b0, DEST_NONE, 16'h0);
						res[1] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd8, 1'b0, {1'b0, REG_H}, nv);
						cnt = 2'd2;
					end
					OP_LD_NN_SP: begin
						nv = nn + 16'd1;
						res[0] = mk_result(RK_WRITE, nn, st.sp[7:0], 5'd0, 1'b0, DEST_NONE, 16'h0);
						res[1] = mk_result(RK_WRITE, nv, st.sp[15:8], 5'd0, 1'b0, DEST_NONE, 16'h0);
						res[2] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd20, 1'b0, DEST_NONE, 16'h0);
						cnt = 2'd3;
					end
					default: begin
						res[0] = mk_result(RK_DONE, 16'h0, 8'h0, 5'd0, 1'b1, DEST_NONE, 16'h0);
					end
				endcase
			end
		end else if (st.read_pending) begin
			if (t == 3'd7) begin
				t = REG_A;
			end
			regs_v[t] = read_data;
			nv = {regs_v[REG_H], regs_v[REG_L]};
			if (st.pend_step == STEP_INC) begin
				nv = nv + 16'd1;
			end else if (st.pend_step == STEP_DEC) begin
				nv = nv - 16'd1;
			end
			regs_v[REG_H] = nv[15:8];
			regs_v[REG_L] = nv[7:0];
			nxt.regs = regs_v;
			nxt.read_pending = 1'b0;
			res[0] = mk_result(RK_DONE, 16'h0, 8'h0, st.pend_cycles, 1'b0, {1'b0, t},
				{8'h0, regs_v[t]});
			cnt = 2'd1;
		end
	end

endmodule

[src/clsu_emit.sv]
// result sequencer and output register
module clsu_emit import clsu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_live,
	input  result_t [2:0] res,
	input  logic [1:0]    cnt,
	input  logic          out_stall,
	output logic          out_valid,
	output result_t       out_item,
	output logic          commit
);

	`include "cpu_load_store_unit_core_defines.svh"

	logic [1:0] idx_q;
	logic       out_valid_q;
	result_t    out_q;
	result_t    sel;
	logic       load;
	logic       last;

	assign load   = !out_valid_q || !out_stall;
	assign last   = (idx_q == cnt - 2'd1);
	assign commit = item_live && (cnt == 2'd0 || (load && last));

	always_comb begin
		case (idx_q)
			2'd1: sel = res[1];
			2'd2: sel = res[2];
			default: sel = res[0];
		endcase
		sel.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			if (item_live && cnt != 2'd0) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && item_live && cnt != 2'd0) begin
			out_q <= sel;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`CLSU_ASSERT_NOW(a_idx_in_range, !item_live || cnt == 2'd0 || idx_q < cnt, "result index past count")
	`CLSU_ASSERT_NOW(a_idx_idle_zero, item_live || idx_q == 2'd0, "result index not cleared")
	`CLSU_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall, $stable(out_q), "stalled result moved")

endmodule

[src/cpu_load_store_unit_core.sv]
// path: an item is held at the input register, its results are formed from it
//   combinationally and registered in turn in the output register, which shows them
// throughput: one result per cycle while not stalled; an item holds the input
//   register until its last result enters the single output register carrying them
// reset: arst_n clears the register file, SP, the pending read and both valid flags
// top level of the load/store unit
module cpu_load_store_unit_core import clsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  opcode,
	input  logic [7:0]  imm_low,
	input  logic [7:0]  imm_high,
	input  logic [7:0]  read_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] address,
	output logic [7:0]  write_data,
	output logic [4:0]  cycles,
	output logic        unsupported,
	output logic [3:0]  dest_index,
	output logic [15:0] dest_value,
	output logic        last_of_run
);

	`include "cpu_load_store_unit_core_defines.svh"

	logic          valid_s1;
	logic          kind_s1;
	logic [7:0]    opcode_s1;
	logic [7:0]    imm_low_s1;
	logic [7:0]    imm_high_s1;
	logic [7:0]    read_data_s1;
	state_t        st_q;
	state_t        nxt;
	result_t [2:0] res;
	logic [1:0]    cnt;
	logic          commit;
	result_t       out_item;
	logic          accept;

	assign item_stall = valid_s1 && !commit;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				st_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= kind;
			opcode_s1    <= opcode;
			imm_low_s1   <= imm_low;
			imm_high_s1  <= imm_high;
			read_data_s1 <= read_data;
		end
	end

	clsu_exec u_exec (
		.kind      (kind_s1),
		.opcode    (opcode_s1),
		.imm_low   (imm_low_s1),
		.imm_high  (imm_high_s1),
		.read_data (read_data_s1),
		.st        (st_q),
		.res       (res),
		.cnt       (cnt),
		.nxt       (nxt)
	);

	clsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_live (valid_s1),
		.res       (res),
		.cnt       (cnt),
		.out_stall (result_stall),
		.out_valid (result_valid),
		.out_item  (out_item),
		.commit    (commit)
	);

	assign result_kind = out_item.kind;
	assign address     = out_item.address;
	assign write_data  = out_item.write_data;
	assign cycles      = out_item.cycles;
	assign unsupported = out_item.unsupported;
	assign dest_index  = out_item.dest_index;
	assign dest_value  = out_item.dest_value;
	assign last_of_run = out_item.last;

	`CLSU_ASSERT_NEXT(a_state_hold, !commit, $stable(st_q), "state changed without commit")
	`CLSU_ASSERT_NOW(a_stray_data, !(valid_s1 && kind_s1 && !st_q.read_pending) || cnt == 2'd0, "results for stray read data")
	`CLSU_ASSERT_NOW(a_done_is_last, !(result_valid && result_kind == RK_DONE) || last_of_run, "completion not last")

endmodule

[sim/cpu_load_store_unit_core_test.sv]
// self-checking testbench of the load/store unit with a scoreboard and random handshake timing
`timescale 1ns / 1ps

module cpu_load_store_unit_core_test;
	import clsu_pkg::*;

	localparam logic KIND_INSTR = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [7:0] OP_LD_A_N  = 8'h3E;
	localparam logic [7:0] OP_LD_B_HL = 8'h46;
	localparam logic [7:0] OP_LD_A_HL = 8'h7E;
	localparam logic [7:0] OP_LD_A_B  = 8'h78;
	localparam logic [7:0] OP_OUT_N   = 8'hD3;

	// opcode register field to register file index, (HL) slot never used
	localparam logic [7:0][2:0] CODE_REG = {REG_A, REG_A, REG_L, REG_H, REG_E, REG_D, REG_C,
		REG_B};

	localparam logic [19:0][7:0] LOAD_OPS = {OP_LD_HL_IND_N, OP_LD_BC_NN, OP_LD_DE_NN,
		OP_LD_HL_NN, OP_LD_SP_NN, OP_LD_SP_HL, OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_NN,
		OP_LD_A_HLI, OP_LD_A_HLD, OP_LDH_A_N, OP_LD_BC_A, OP_LD_DE_A, OP_LD_NN_A,
		OP_LDH_C_A, OP_LDH_N_A, OP_LD_HLI_A, OP_LD_HLD_A, OP_LD_NN_SP};

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        kind;
	logic [7:0]  opcode;
	logic [7:0]  imm_low;
	logic [7:0]  imm_high;
	logic [7:0]  read_data;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  result_kind;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [4:0]  cycles;
	logic        unsupported;
	logic [3:0]  dest_index;
	logic [15:0] dest_value;
	logic        last_of_run;

	cpu_load_store_unit_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.opcode(opcode),
		.imm_low(imm_low),
		.imm_high(imm_high),
		.read_data(read_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_kind(result_kind),
		.address(address),
		.write_data(write_data),
		.cycles(cycles),
		.unsupported(unsupported),
		.dest_index(dest_index),
		.dest_value(dest_value),
		.last_of_run(last_of_run)
	);

	class load_store_scoreboard;
		logic [7:0]  regs [7];
		logic [15:0] sp;
		logic        rd_pending;
		logic [2:0]  rd_target;
		logic [1:0]  rd_step;
		logic [4:0]  rd_cycles;
		result_t     expected_q[$];
		result_t     batch[$];
		int          errors;

		function new();
			foreach (regs[i]) regs[i] = 8'd0;
			sp = 16'd0;
			rd_pending = 1'b0;
			rd_target = REG_A;
			rd_step = STEP_NONE;
			rd_cycles = 5'd0;
			errors = 0;
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function string show(result_t r);
			return $sformatf("kind %0d addr %h data %h cyc %0d unsup %0b dest %0d val %h last %0b",
				r.kind, r.address, r.write_data, r.cycles, r.unsupported, r.dest_index,
				r.dest_value, r.last);
		endfunction

		function void emit(logic [1:0] k, logic [15:0] addr, logic [7:0] data,
				logic [4:0] cyc, logic unsup, logic [3:0] dest, logic [15:0] val);
			result_t r;
			r.kind = k;
			r.address = addr;
			r.write_data = data;
			r.cycles = cyc;
			r.unsupported = unsup;
			r.dest_index = dest;
			r.dest_value = val;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function void complete(logic [4:0] cyc, logic [3:0] dest, logic [15:0] val);
			emit(RK_DONE, 16'd0, 8'd0, cyc, 1'b0, dest, val);
		endfunction

		function void store(logic [15:0] addr, logic [7:0] data, logic [4:0] cyc);
			emit(RK_WRITE, addr, data, 5'd0, 1'b0, DEST_NONE, 16'd0);
			complete(cyc, DEST_NONE, 16'd0);
		endfunction

		function void request(logic [15:0] addr, logic [2:0] target, logic [1:0] step,
				logic [4:0] cyc);
			rd_pending = 1'b1;
			rd_target = target;
			rd_step = step;
			rd_cycles = cyc;
			emit(RK_READ, addr, 8'd0, 5'd0, 1'b0, DEST_NONE, 16'd0);
		endfunction

		function logic [15:0] pair_of(logic [2:0] hi);
			return {regs[hi], regs[hi + 3'd1]};
		endfunction

		function void set_pair(logic [2:0] hi, logic [15:0] v);
			regs[hi] = v[15:8];
			regs[hi + 3'd1] = v[7:0];
		endfunction

		function void execute(logic [7:0] op, logic [7:0] n, logic [7:0] nh);
			logic [15:0] hl;
			logic [15:0] nn;
			logic [15:0] nv;
			logic [7:0]  a;
			logic [2:0]  dst;
			logic [2:0]  src;
			hl = pair_of(REG_H);
			nn = {nh, n};
			a = regs[REG_A];
			dst = CODE_REG[op[5:3]];
			src = CODE_REG[op[2:0]];
			if (op[7:6] == 2'b01 && op != OP_HALT) begin
				if (op[5:3] == CODE_HL_IND)
					store(hl, regs[src], 5'd8);
				else if (op[2:0] == CODE_HL_IND)
					request(hl, dst, STEP_NONE, 5'd8);
				else begin
					regs[dst] = regs[src];
					complete(5'd4, {1'b0, dst}, {8'd0, regs[dst]});
				end
			end else if (op[7:6] == 2'b00 && op[2:0] == CODE_HL_IND && op != OP_LD_HL_IND_N) begin
				regs[dst] = n;
				complete(5'd8, {1'b0, dst}, {8'd0, n});
			end else begin
				case (op)
					OP_LD_BC_NN: begin
						set_pair(REG_B, nn);
						complete(5'd12, {1'b0, REG_B}, nn);
					end
					OP_LD_DE_NN: begin
						set_pair(REG_D, nn);
						complete(5'd12, {1'b0, REG_D}, nn);
					end
					OP_LD_HL_NN: begin
						set_pair(REG_H, nn);
						complete(5'd12, {1'b0, REG_H}, nn);
					end
					OP_LD_SP_NN: begin
						sp = nn;
						complete(5'd12, DEST_SP, nn);
					end
					OP_LD_SP_HL: begin
						sp = hl;
						complete(5'd8, DEST_SP, hl);
					end
					OP_LD_HL_IND_N: store(hl, n, 5'd12);
					OP_LD_A_BC: request(pair_of(REG_B), REG_A, STEP_NONE, 5'd8);
					OP_LD_A_DE: request(pair_of(REG_D), REG_A, STEP_NONE, 5'd8);
					OP_LD_A_NN: request(nn, REG_A, STEP_NONE, 5'd16);
					OP_LD_A_HLI: request(hl, REG_A, STEP_INC, 5'd8);
					OP_LD_A_HLD: request(hl, REG_A, STEP_DEC, 5'd8);
					OP_LDH_A_N: request(HIGH_PAGE + {8'd0, n}, REG_A, STEP_NONE, 5'd12);
					OP_LD_BC_A: store(pair_of(REG_B), a, 5'd8);
					OP_LD_DE_A: store(pair_of(REG_D), a, 5'd8);
					OP_LD_NN_A: store(nn, a, 5'd16);
					OP_LDH_C_A: store(HIGH_PAGE + {8'd0, regs[REG_C]}, a, 5'd8);
					OP_LDH_N_A: store(HIGH_PAGE + {8'd0, n}, a, 5'd12);
					OP_LD_HLI_A, OP_LD_HLD_A: begin
						nv = (op == OP_LD_HLI_A) ? hl + 16'd1 : hl - 16'd1;
						emit(RK_WRITE, hl, a, 5'd0, 1'b0, DEST_NONE, 16'd0);
						set_pair(REG_H, nv);
						complete(5'd8, {1'b0, REG_H}, nv);
					end
					OP_LD_NN_SP: begin
						emit(RK_WRITE, nn, sp[7:0], 5'd0, 1'b0, DEST_NONE, 16'd0);
						emit(RK_WRITE, nn + 16'd1, sp[15:8], 5'd0, 1'b0, DEST_NONE, 16'd0);
						complete(5'd20, DEST_NONE, 16'd0);
					end
					default: emit(RK_DONE, 16'd0, 8'd0, 5'd0, 1'b1, DEST_NONE, 16'd0);
				endcase
			end
		endfunction

		function int note_item(logic k, logic [7:0] op, logic [7:0] n, logic [7:0] nh,
				logic [7:0] rd);
			result_t     r;
			logic [15:0] hl;
			batch.delete();
			if (k == KIND_INSTR) begin
				rd_pending = 1'b0;
				execute(op, n, nh);
			end else if (rd_pending) begin
				rd_pending = 1'b0;
				regs[rd_target] = rd;
				hl = pair_of(REG_H);
				if (rd_step == STEP_INC)
					set_pair(REG_H, hl + 16'd1);
				else if (rd_step == STEP_DEC)
					set_pair(REG_H, hl - 16'd1);
				complete(rd_cycles, {1'b0, rd_target}, {8'd0, regs[rd_target]});
			end
			if (batch.size() == 0)
				return 0;
			r = batch.pop_back();
			r.last = 1'b1;
			batch.push_back(r);
			foreach (batch[i]) expected_q.push_back(batch[i]);
			return batch.size();
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_q.size() == 0) begin
				note_error({"result with nothing expected: ", show(got)});
				return;
			end
			exp = expected_q.pop_front();
			if (got.kind !== exp.kind || got.address !== exp.address ||
					got.write_data !== exp.write_data || got.cycles !== exp.cycles ||
					got.unsupported !== exp.unsupported || got.dest_index !== exp.dest_index ||
					got.dest_value !== exp.dest_value || got.last !== exp.last)
				note_error({"expected ", show(exp), " got ", show(got)});
		endfunction
	endclass

	load_store_scoreboard model = new();
	int burst_left = 0;
	int sent_items = 0;
	int stall_pct = 0;
	int stall_window = 0;
	int wait_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			model.check_result({result_kind, address, write_data, cycles, unsupported,
				dest_index, dest_value, last_of_run});
		if (stall_window == 0) begin
			stall_pct = $urandom_range(0, 3) * 30;
			stall_window = $urandom_range(20, 80);
		end
		stall_window--;
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic send_item(input logic k, input logic [7:0] op, input logic [7:0] n,
			input logic [7:0] nh, input logic [7:0] rd);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
		burst_left--;
		item_valid <= 1'b1;
		kind <= k;
		opcode <= op;
		imm_low <= n;
		imm_high <= nh;
		read_data <= rd;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		void'(model.note_item(k, op, n, nh, rd));
		sent_items++;
	endtask

	task automatic send_op(input logic [7:0] op);
		logic [15:0] imm;
		case ($urandom_range(0, 9))
			0: imm = 16'hFFFF;
			1: imm = 16'h0000;
			default: imm = 16'($urandom);
		endcase
		send_item(KIND_INSTR, op, imm[7:0], imm[15:8], 8'($urandom));
	endtask

	task automatic send_data();
		send_item(KIND_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] pick_load();
		case ($urandom_range(0, 2))
			0: return {2'b01, 6'($urandom)};
			1: return {2'b00, 3'($urandom), CODE_HL_IND};
			default: return LOAD_OPS[$urandom_range(0, 19)];
		endcase
	endfunction

	initial begin
		int choice;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		kind <= KIND_INSTR;
		opcode <= 8'd0;
		imm_low <= 8'd0;
		imm_high <= 8'd0;
		read_data <= 8'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases: wraps, high page, dropped and stray reads, unsupported codes
		send_item(KIND_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_item(KIND_INSTR, OP_LD_SP_NN, 8'h34, 8'h12, 8'h00);
		send_item(KIND_INSTR, OP_LD_NN_SP, 8'hFF, 8'hFF, 8'h00);
		send_item(KIND_INSTR, OP_LD_HL_NN, 8'hFF, 8'hFF, 8'h00);
		send_item(KIND_INSTR, OP_LD_A_N, 8'hFF, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LD_HLI_A, 8'h00, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LD_HLD_A, 8'h00, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LD_A_HLI, 8'h00, 8'h00, 8'h00);
		send_item(KIND_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LD_A_HLD, 8'h00, 8'h00, 8'h00);
		send_item(KIND_DATA, 8'h00, 8'h00, 8'h00, 8'hA5);
		send_item(KIND_INSTR, OP_LDH_N_A, 8'h00, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LDH_A_N, 8'hFF, 8'h00, 8'h00);
		send_item(KIND_DATA, 8'h00, 8'h00, 8'h00, 8'h5A);
		send_item(KIND_INSTR, OP_LD_HL_IND_N, 8'h80, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LD_A_HL, 8'h00, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LD_BC_NN, 8'h00, 8'h00, 8'h00);
		send_item(KIND_DATA, 8'h00, 8'h00, 8'h00, 8'h11);
		send_item(KIND_INSTR, OP_LD_B_HL, 8'h00, 8'h00, 8'h00);
		send_item(KIND_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h22);
		send_item(KIND_INSTR, OP_HALT, 8'h00, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_OUT_N, 8'hFF, 8'hFF, 8'hFF);
		send_item(KIND_INSTR, OP_LD_SP_HL, 8'h00, 8'h00, 8'h00);
		send_item(KIND_INSTR, OP_LD_A_B, 8'h00, 8'h00, 8'h00);

		// mostly well-formed loads with their read data, some noise
		while (sent_items < 260) begin
			choice = $urandom_range(0, 99);
			if (choice < 6)
				send_data();
			else if (choice < 12)
				send_op(8'($urandom));
			else begin
				send_op(pick_load());
				if (model.rd_pending) begin
					choice = $urandom_range(0, 99);
					if (choice < 88)
						send_data();
					if (choice >= 80 && choice < 88)
						send_data();
				end
			end
		end
		item_valid <= 1'b0;

		for (wait_cycles = 0; wait_cycles < 20000 && model.expected_q.size() > 0; wait_cycles++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (model.expected_q.size() > 0)
			model.note_error($sformatf("%0d results never arrived", model.expected_q.size()));
		if (model.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/clsu_pkg.sv
src/clsu_exec.sv
src/clsu_emit.sv
src/cpu_load_store_unit_core.sv
sim/cpu_load_store_unit_core_test.sv
